>>> design/assert_macros.svh
// Assertion macros used by the button press classifier lane module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checks that a property holds at every clock edge outside reset.
`define BPC_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("%m: assertion failed");

// Checks that a consequent holds in the cycle after its antecedent.
`define BPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`else

`define BPC_ASSERT(lbl, clk, rst_n, prop)
`define BPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

>>> design/bpc_pkg.sv
// Package with constants and types of the button press classifier.
`default_nettype none

package bpc_pkg;

  localparam int unsigned NUM_BUTTONS = 4;

  localparam int unsigned DEBOUNCE_W = 8;
  localparam int unsigned MIN_PRESS_W = 10;
  localparam int unsigned LONG_HOLD_W = 16;
  localparam int unsigned DBL_WINDOW_W = 11;
  localparam int unsigned STEADY_AGE_W = 8;
  localparam int unsigned PRESS_AGE_W = 16;
  localparam int unsigned RELEASE_AGE_W = 16;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [DEBOUNCE_W-1:0] DEBOUNCE_RST = DEBOUNCE_W'(20);
  localparam logic [MIN_PRESS_W-1:0] MIN_PRESS_RST = MIN_PRESS_W'(30);
  localparam logic [LONG_HOLD_W-1:0] LONG_HOLD_RST = LONG_HOLD_W'(5000);
  localparam logic [DBL_WINDOW_W-1:0] DBL_WINDOW_RST = DBL_WINDOW_W'(300);
  localparam logic [NUM_BUTTONS-1:0] ENABLE_RST = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DEBOUNCE      = 3'd0,
    CFG_MIN_PRESS     = 3'd1,
    CFG_LONG_HOLD     = 3'd2,
    CFG_DOUBLE_WINDOW = 3'd3,
    CFG_ENABLE_MASK   = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic [DEBOUNCE_W-1:0]   debounce;
    logic [MIN_PRESS_W-1:0]  min_press;
    logic [LONG_HOLD_W-1:0]  long_hold;
    logic [DBL_WINDOW_W-1:0] dbl_window;
  } bpc_cfg_t;

  typedef struct packed {
    logic short_evt;
    logic long_evt;
    logic dbl_evt;
    logic held;
  } bpc_evt_t;

  typedef struct packed {
    logic [NUM_BUTTONS-1:0] short_events;
    logic [NUM_BUTTONS-1:0] long_events;
    logic [NUM_BUTTONS-1:0] double_events;
    logic [NUM_BUTTONS-1:0] pressed_levels;
  } bpc_result_t;

endpackage

`default_nettype wire

>>> design/bpc_if.sv
// Valid-ready channel interfaces for the tick requests and the result requests.
`default_nettype none

interface bpc_in_if;
  import bpc_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [NUM_BUTTONS-1:0] raw_levels;

  modport source (output valid, output raw_levels, input ready);
  modport sink (input valid, input raw_levels, output ready);
endinterface

interface bpc_out_if;
  import bpc_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [NUM_BUTTONS-1:0] short_events;
  logic [NUM_BUTTONS-1:0] long_events;
  logic [NUM_BUTTONS-1:0] double_events;
  logic [NUM_BUTTONS-1:0] pressed_levels;

  modport source (output valid, output short_events, output long_events,
                  output double_events, output pressed_levels, input ready);
  modport sink (input valid, input short_events, input long_events,
                input double_events, input pressed_levels, output ready);
endinterface

`default_nettype wire

>>> design/button_press_classifier.sv
// Top level of the button press classifier: config registers, lanes, merge and output skid.
// The result of an accepted tick request is registered; each enabled lane steps on it.
// Throughput: one tick request per cycle while the skid stage is empty.
// A result that waits is held in the output register and one more request fits a skid stage.
// Reset (rst_ni low, asynchronous) clears all button state, restores the register defaults
// and empties the output stages; no clearing pass follows.
`default_nettype none

module button_press_classifier (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [bpc_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [bpc_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  bpc_in_if.sink                              in_chan,
  bpc_out_if.source                           out_chan
);
  import bpc_pkg::*;

  bpc_cfg_t               cfg_q;
  logic [NUM_BUTTONS-1:0] enable_q;
  logic                   accept;
  bpc_evt_t               evt [NUM_BUTTONS];
  bpc_result_t            merged;
  bpc_result_t            out_q, out_d, skid_q, skid_d;
  logic                   out_vld_q, out_vld_d, skid_vld_q, skid_vld_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.debounce <= DEBOUNCE_RST;
      cfg_q.min_press <= MIN_PRESS_RST;
      cfg_q.long_hold <= LONG_HOLD_RST;
      cfg_q.dbl_window <= DBL_WINDOW_RST;
      enable_q <= ENABLE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_DEBOUNCE:      cfg_q.debounce <= cfg_data_i[DEBOUNCE_W-1:0];
        CFG_MIN_PRESS:     cfg_q.min_press <= cfg_data_i[MIN_PRESS_W-1:0];
        CFG_LONG_HOLD:     cfg_q.long_hold <= cfg_data_i[LONG_HOLD_W-1:0];
        CFG_DOUBLE_WINDOW: cfg_q.dbl_window <= cfg_data_i[DBL_WINDOW_W-1:0];
        CFG_ENABLE_MASK:   enable_q <= cfg_data_i[NUM_BUTTONS-1:0];
        default: begin
        end
      endcase
    end
  end

  assign in_chan.ready = !skid_vld_q;
  assign accept = in_chan.valid && in_chan.ready;

  for (genvar b = 0; b < NUM_BUTTONS; b++) begin : g_lane
    bpc_lane u_lane (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .step_i        (accept && enable_q[b]),
      .raw_pressed_i (!in_chan.raw_levels[b]),
      .cfg_i         (cfg_q),
      .evt_o         (evt[b])
    );

    assign merged.short_events[b] = enable_q[b] && evt[b].short_evt;
    assign merged.long_events[b] = enable_q[b] && evt[b].long_evt;
    assign merged.double_events[b] = enable_q[b] && evt[b].dbl_evt;
    assign merged.pressed_levels[b] = enable_q[b] && evt[b].held;
  end

  always_comb begin
    out_d = out_q;
    out_vld_d = out_vld_q;
    skid_d = skid_q;
    skid_vld_d = skid_vld_q;
    if (!out_vld_q || out_chan.ready) begin
      if (skid_vld_q) begin
        out_d = skid_q;
        out_vld_d = 1'b1;
        skid_vld_d = 1'b0;
      end else begin
        out_d = merged;
        out_vld_d = accept;
      end
    end else if (accept) begin
      skid_d = merged;
      skid_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
    skid_q <= skid_d;
  end

  assign out_chan.valid = out_vld_q;
  assign out_chan.short_events = out_q.short_events;
  assign out_chan.long_events = out_q.long_events;
  assign out_chan.double_events = out_q.double_events;
  assign out_chan.pressed_levels = out_q.pressed_levels;

endmodule

`default_nettype wire

>>> design/bpc_lane.sv
// Per-button lane: debounce, press timers and press classification.
`default_nettype none
`include "assert_macros.svh"

module bpc_lane (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic              raw_pressed_i,
  input  bpc_pkg::bpc_cfg_t cfg_i,
  output bpc_pkg::bpc_evt_t evt_o
);
  import bpc_pkg::*;

  logic                     last_raw_q, last_raw_d;
  logic                     stable_q, stable_d;
  logic [STEADY_AGE_W-1:0]  steady_age_q, steady_age_d;
  logic [PRESS_AGE_W-1:0]   press_age_q, press_age_d, press_inc;
  logic [RELEASE_AGE_W-1:0] release_age_q, release_age_d, release_inc;
  logic                     long_fired_q, long_fired_d;
  logic                     take;

  always_comb begin
    press_inc = (&press_age_q) ? press_age_q : press_age_q + PRESS_AGE_W'(1);
    release_inc = (&release_age_q) ? release_age_q : release_age_q + RELEASE_AGE_W'(1);

    press_age_d = press_inc;
    release_age_d = release_inc;
    long_fired_d = long_fired_q;
    last_raw_d = raw_pressed_i;
    evt_o = '0;

    if (raw_pressed_i != last_raw_q) begin
      steady_age_d = '0;
    end else if (&steady_age_q) begin
      steady_age_d = steady_age_q;
    end else begin
      steady_age_d = steady_age_q + STEADY_AGE_W'(1);
    end

    take = (steady_age_d >= cfg_i.debounce) && (raw_pressed_i != stable_q);
    stable_d = take ? raw_pressed_i : stable_q;

    if (take && raw_pressed_i) begin
      press_age_d = '0;
      long_fired_d = 1'b0;
    end else if (take) begin
      if (press_inc >= cfg_i.long_hold) begin
        if (!long_fired_q) begin
          evt_o.long_evt = 1'b1;
          long_fired_d = 1'b1;
        end
      end else if (press_inc >= PRESS_AGE_W'(cfg_i.min_press)) begin
        if (release_inc < RELEASE_AGE_W'(cfg_i.dbl_window)) begin
          evt_o.dbl_evt = 1'b1;
        end else begin
          evt_o.short_evt = 1'b1;
        end
      end
      release_age_d = '0;
    end

    if (stable_d && !long_fired_d && (press_age_d >= cfg_i.long_hold)) begin
      evt_o.long_evt = 1'b1;
      long_fired_d = 1'b1;
    end

    evt_o.held = stable_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_raw_q <= 1'b0;
      stable_q <= 1'b0;
      steady_age_q <= '0;
      press_age_q <= '0;
      release_age_q <= '1;
      long_fired_q <= 1'b0;
    end else if (step_i) begin
      last_raw_q <= last_raw_d;
      stable_q <= stable_d;
      steady_age_q <= steady_age_d;
      press_age_q <= press_age_d;
      release_age_q <= release_age_d;
      long_fired_q <= long_fired_d;
    end
  end

  `BPC_ASSERT(a_one_class, clk_i, rst_ni, $countones({evt_o.short_evt, evt_o.long_evt, evt_o.dbl_evt}) <= 1)
  `BPC_ASSERT_NEXT(a_long_marks, clk_i, rst_ni, step_i && evt_o.long_evt, long_fired_q)
  `BPC_ASSERT_NEXT(a_release_clears, clk_i, rst_ni, step_i && (evt_o.short_evt || evt_o.dbl_evt), release_age_q == '0 && !stable_q)
  `BPC_ASSERT_NEXT(a_frozen, clk_i, rst_ni, !step_i, $stable(press_age_q) && $stable(stable_q))

endmodule

`default_nettype wire

>>> sim/tb.sv
// Self-checking testbench of the button press classifier: debounce and press classification.
`timescale 1ns / 100ps

module tb;
  import bpc_pkg::*;

  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned HOLD_CAP = 300;
  localparam int unsigned SINK_HOLD = 300;

  logic                  clk;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  bpc_in_if  in_chan ();
  bpc_out_if out_chan ();

  button_press_classifier uut (
    .clk_i      (clk),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_chan    (in_chan),
    .out_chan   (out_chan)
  );

  // Predicted register contents.
  logic [DEBOUNCE_W-1:0]   cfg_debounce;
  logic [MIN_PRESS_W-1:0]  cfg_min_press;
  logic [LONG_HOLD_W-1:0]  cfg_long_hold;
  logic [DBL_WINDOW_W-1:0] cfg_window;
  logic [NUM_BUTTONS-1:0]  cfg_mask;

  // Predicted per-button state.
  logic                     btn_raw_held [NUM_BUTTONS];
  logic                     btn_stable [NUM_BUTTONS];
  logic [STEADY_AGE_W-1:0]  btn_steady_age [NUM_BUTTONS];
  logic [PRESS_AGE_W-1:0]   btn_press_age [NUM_BUTTONS];
  logic [RELEASE_AGE_W-1:0] btn_release_age [NUM_BUTTONS];
  logic                     btn_long_done [NUM_BUTTONS];

  // Stimulus schedule of the raw pin levels.
  bit          sched_pressed [NUM_BUTTONS];
  int unsigned sched_left [NUM_BUTTONS];

  bpc_result_t tick_results_q[$];
  bpc_result_t predicted;
  int unsigned errors;
  int unsigned ticks_taken;
  int unsigned reg_writes;
  int unsigned short_total;
  int unsigned long_total;
  int unsigned double_total;
  int unsigned quiet_cycles;
  int unsigned hold_request;
  bit          steady_flow;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic bpc_result_t classify_tick(logic [NUM_BUTTONS-1:0] levels);
    bpc_result_t r;
    logic        pressed;
    r = '0;
    for (int b = 0; b < NUM_BUTTONS; b++) begin
      if (cfg_mask[b]) begin
        pressed = ~levels[b];
        if (btn_press_age[b] != '1) btn_press_age[b] = btn_press_age[b] + 1'b1;
        if (btn_release_age[b] != '1) btn_release_age[b] = btn_release_age[b] + 1'b1;
        if (pressed != btn_raw_held[b]) begin
          btn_raw_held[b] = pressed;
          btn_steady_age[b] = '0;
        end else if (btn_steady_age[b] != '1) begin
          btn_steady_age[b] = btn_steady_age[b] + 1'b1;
        end
        if (btn_steady_age[b] >= cfg_debounce && pressed != btn_stable[b]) begin
          btn_stable[b] = pressed;
          if (pressed) begin
            btn_press_age[b] = '0;
            btn_long_done[b] = 1'b0;
          end else begin
            if (btn_press_age[b] >= cfg_long_hold) begin
              if (!btn_long_done[b]) begin
                r.long_events[b] = 1'b1;
                btn_long_done[b] = 1'b1;
              end
            end else if (btn_press_age[b] >= cfg_min_press) begin
              if (btn_release_age[b] < cfg_window) r.double_events[b] = 1'b1;
              else r.short_events[b] = 1'b1;
            end
            btn_release_age[b] = '0;
          end
        end
        if (btn_stable[b] && !btn_long_done[b] && btn_press_age[b] >= cfg_long_hold) begin
          r.long_events[b] = 1'b1;
          btn_long_done[b] = 1'b1;
        end
        r.pressed_levels[b] = btn_stable[b];
      end
    end
    return r;
  endfunction

  function automatic void check_field(string name, logic [NUM_BUTTONS-1:0] want,
                                      logic [NUM_BUTTONS-1:0] got);
    if (got !== want) begin
      $error("%s: expected %h, actual %h", name, want, got);
      errors++;
    end
  endfunction

  function automatic int unsigned draw_gap();
    return steady_flow ? 0 : $urandom_range(0, 19);
  endfunction

  // Hold lengths cluster around the debounce, minimum press and long hold thresholds and half the window.
  function automatic int unsigned pick_hold();
    int unsigned target;
    case ($urandom_range(0, 5))
      0: target = $urandom_range(1, cfg_debounce + 1);
      1: target = cfg_min_press;
      2: target = cfg_long_hold;
      3: target = cfg_window / 2;
      default: target = $urandom_range(1, 3 * cfg_debounce + 20);
    endcase
    if (target > HOLD_CAP) target = HOLD_CAP;
    target = target + $urandom_range(0, 4);
    return (target > 2) ? target - 2 : 1;
  endfunction

  function automatic logic [NUM_BUTTONS-1:0] next_raw();
    logic [NUM_BUTTONS-1:0] raw;
    for (int b = 0; b < NUM_BUTTONS; b++) begin
      if (sched_left[b] == 0) begin
        sched_pressed[b] = ~sched_pressed[b];
        sched_left[b] = pick_hold();
      end
      sched_left[b]--;
      raw[b] = ~sched_pressed[b];
    end
    if ($urandom_range(0, 19) == 0) raw = NUM_BUTTONS'($urandom_range(0, 15));
    return raw;
  endfunction

  task automatic send_tick(logic [NUM_BUTTONS-1:0] raw);
    int unsigned gap;
    gap = draw_gap();
    repeat (gap) begin
      @(negedge clk);
      in_chan.valid <= 1'b0;
    end
    @(negedge clk);
    in_chan.valid <= 1'b1;
    in_chan.raw_levels <= raw;
    do @(posedge clk); while (!(in_chan.valid && in_chan.ready));
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_chan.valid <= 1'b0;
    while (tick_results_q.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic set_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= value;
    @(negedge clk);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_DEBOUNCE:      cfg_debounce = value[DEBOUNCE_W-1:0];
      CFG_MIN_PRESS:     cfg_min_press = value[MIN_PRESS_W-1:0];
      CFG_LONG_HOLD:     cfg_long_hold = value[LONG_HOLD_W-1:0];
      CFG_DOUBLE_WINDOW: cfg_window = value[DBL_WINDOW_W-1:0];
      CFG_ENABLE_MASK:   cfg_mask = value[NUM_BUTTONS-1:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic test_reset_defaults();
    repeat (150) send_tick(next_raw());
  endtask

  task automatic test_directed();
    wait_idle();
    set_reg(CFG_DEBOUNCE, 16'd0);
    set_reg(CFG_MIN_PRESS, 16'd1);
    set_reg(CFG_LONG_HOLD, 16'd0);
    set_reg(CFG_DOUBLE_WINDOW, 16'd2047);
    set_reg(CFG_ENABLE_MASK, 16'hF);
    send_tick(4'hF);
    send_tick(4'h0);
    send_tick(4'h0);
    send_tick(4'hF);
    wait_idle();
    set_reg(CFG_LONG_HOLD, 16'd3);
    send_tick(4'h0);
    send_tick(4'h0);
    send_tick(4'h0);
    send_tick(4'hF);
    send_tick(4'h0);
    send_tick(4'hF);
    send_tick(4'h5);
    send_tick(4'hA);
    send_tick(4'hF);
    wait_idle();
    set_reg(CFG_DOUBLE_WINDOW, 16'd1);
    set_reg(CFG_MIN_PRESS, 16'd1023);
    send_tick(4'h0);
    send_tick(4'hF);
    wait_idle();
    set_reg(CFG_MIN_PRESS, 16'd0);
    set_reg(CFG_ENABLE_MASK, 16'h5);
    send_tick(4'h0);
    send_tick(4'hF);
    send_tick(4'h0);
    wait_idle();
    set_reg(CFG_ENABLE_MASK, 16'h0);
    send_tick(4'h0);
    send_tick(4'hF);
    wait_idle();
    set_reg(CFG_ENABLE_MASK, 16'hA);
    send_tick(4'hF);
    send_tick(4'h0);
    send_tick(4'h0);
    send_tick(4'hF);
  endtask

  task automatic test_random_settings();
    for (int p = 0; p < 5; p++) begin
      wait_idle();
      set_reg(CFG_DEBOUNCE, CFG_DATA_W'($urandom_range(0, 6)));
      set_reg(CFG_MIN_PRESS, CFG_DATA_W'($urandom_range(0, 12)));
      set_reg(CFG_LONG_HOLD, CFG_DATA_W'($urandom_range(1, 50)));
      set_reg(CFG_DOUBLE_WINDOW, CFG_DATA_W'($urandom_range(1, 60)));
      set_reg(CFG_ENABLE_MASK, CFG_DATA_W'((p == 0) ? 15 : $urandom_range(1, 15)));
      steady_flow = (p == 2);
      repeat (110) send_tick(next_raw());
    end
    steady_flow = 1'b0;
  endtask

  // Upper data bits beyond each register width are dropped.
  task automatic test_wide_values();
    wait_idle();
    set_reg(CFG_DEBOUNCE, 16'hA502);
    set_reg(CFG_MIN_PRESS, 16'hFFFF);
    set_reg(CFG_LONG_HOLD, 16'hFFFF);
    set_reg(CFG_DOUBLE_WINDOW, 16'hFFFF);
    set_reg(CFG_ENABLE_MASK, 16'hFFF7);
    repeat (100) send_tick(next_raw());
  endtask

  task automatic test_slow_debounce();
    wait_idle();
    set_reg(CFG_DEBOUNCE, 16'd255);
    set_reg(CFG_MIN_PRESS, 16'd100);
    set_reg(CFG_LONG_HOLD, 16'd280);
    set_reg(CFG_DOUBLE_WINDOW, 16'd2000);
    set_reg(CFG_ENABLE_MASK, 16'hF);
    repeat (450) send_tick(next_raw());
  endtask

  // The result side stops for a long stretch while ticks keep coming.
  task automatic test_backpressure();
    wait_idle();
    set_reg(CFG_DEBOUNCE, 16'd2);
    set_reg(CFG_MIN_PRESS, 16'd3);
    set_reg(CFG_LONG_HOLD, 16'd20);
    set_reg(CFG_DOUBLE_WINDOW, 16'd30);
    steady_flow = 1'b1;
    hold_request = SINK_HOLD;
    repeat (60) send_tick(next_raw());
    steady_flow = 1'b0;
    wait_idle();
  endtask

  initial begin : result_sink
    int unsigned stall;
    out_chan.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_request != 0) begin
        stall = hold_request;
        hold_request = 0;
      end else begin
        stall = draw_gap();
      end
      repeat (stall) begin
        @(negedge clk);
        out_chan.ready <= 1'b0;
      end
      @(negedge clk);
      out_chan.ready <= 1'b1;
      do @(posedge clk); while (!(out_chan.valid && out_chan.ready));
    end
  end

  always @(posedge clk) begin
    if (rst_ni) begin
      if (out_chan.valid && out_chan.ready) begin
        if (tick_results_q.size() == 0) begin
          $error("result request arrived with no tick pending");
          errors++;
        end else begin
          predicted = tick_results_q.pop_front();
          check_field("short_events", predicted.short_events, out_chan.short_events);
          check_field("long_events", predicted.long_events, out_chan.long_events);
          check_field("double_events", predicted.double_events, out_chan.double_events);
          check_field("pressed_levels", predicted.pressed_levels, out_chan.pressed_levels);
        end
      end
      if (in_chan.valid && in_chan.ready) begin
        predicted = classify_tick(in_chan.raw_levels);
        tick_results_q.push_back(predicted);
        ticks_taken++;
        short_total += $countones(predicted.short_events);
        long_total += $countones(predicted.long_events);
        double_total += $countones(predicted.double_events);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_ni || (in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles == STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_DEBOUNCE;
    cfg_data_i = '0;
    in_chan.valid = 1'b0;
    in_chan.raw_levels = '1;
    errors = 0;
    ticks_taken = 0;
    reg_writes = 0;
    short_total = 0;
    long_total = 0;
    double_total = 0;
    quiet_cycles = 0;
    hold_request = 0;
    steady_flow = 1'b0;
    cfg_debounce = DEBOUNCE_RST;
    cfg_min_press = MIN_PRESS_RST;
    cfg_long_hold = LONG_HOLD_RST;
    cfg_window = DBL_WINDOW_RST;
    cfg_mask = ENABLE_RST;
    for (int b = 0; b < NUM_BUTTONS; b++) begin
      btn_raw_held[b] = 1'b0;
      btn_stable[b] = 1'b0;
      btn_steady_age[b] = '0;
      btn_press_age[b] = '0;
      btn_release_age[b] = '1;
      btn_long_done[b] = 1'b0;
      sched_pressed[b] = 1'b0;
      sched_left[b] = 0;
    end
    repeat (9) @(negedge clk);
    rst_ni <= 1'b1;

    test_reset_defaults();
    test_directed();
    test_random_settings();
    test_wide_values();
    test_slow_debounce();
    test_backpressure();

    wait_idle();
    repeat (4) @(posedge clk);
    $display("Run covered %0d ticks across %0d register writes, debounce 0 to 255.",
             ticks_taken, reg_writes);
    $display("Predicted events: %0d short, %0d long, %0d double.",
             short_total, long_total, double_total);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+design
design/bpc_pkg.sv
design/bpc_if.sv
design/bpc_lane.sv
design/button_press_classifier.sv
sim/tb.sv
